FILE: hdl/ddou_pkg.sv
// Shared types, constants and table for the odometry update block.
package ddou_pkg;

	localparam int TABLE_ENTRIES = 91;
	localparam logic [22:0] HEAD_FULL = 23'd6283000;
	// (n * W_RECIP) >> 26 == n * 1000 / 19 for n < 2048
	localparam logic [31:0] W_RECIP = 32'd3532046000;
	// (h * MRAD_RECIP) >> 33 == h / 1000 for h < 2**23
	localparam logic [23:0] MRAD_RECIP = 24'd8589935;
	// (m * DEG_RECIP) >> 33 == m * 180 / 3141 for m <= 6283
	localparam logic [28:0] DEG_RECIP = 29'd492260040;
	// (a * POS_RECIP) >> 72 == a / 15625 for a < 2**58
	localparam logic [58:0] POS_RECIP = 59'd302231454903657294;
	localparam logic [7:0] NOISE_RESET = 8'd2;
	localparam logic [7:0] PERIOD_RESET = 8'd5;

	localparam logic [0:0] REG_NOISE = 1'b0;
	localparam logic [0:0] REG_PERIOD = 1'b1;

	localparam logic [2:0] STEP_IDLE = 3'd0;
	localparam logic [2:0] STEP_VEL = 3'd1;
	localparam logic [2:0] STEP_TRIG = 3'd2;
	localparam logic [2:0] STEP_MUL = 3'd3;
	localparam logic [2:0] STEP_ACC = 3'd4;
	localparam logic [2:0] STEP_HEAD = 3'd5;
	localparam logic [2:0] STEP_SCALE = 3'd6;
	localparam logic [2:0] STEP_OUT = 3'd7;

	typedef struct packed {
		logic [9:0] left_count;
		logic [9:0] right_count;
		logic left_reverse;
		logic right_reverse;
	} req_t;

	typedef struct packed {
		logic signed [31:0] x_position;
		logic signed [31:0] y_position;
		logic [12:0] heading_mrad;
		logic report_valid;
		logic [9:0] left_count_out;
		logic [9:0] right_count_out;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic [2:0] step;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} sts_t;

	function automatic logic [9:0] sine_at(input logic [6:0] idx);
		logic [9:0] r;
		case (idx)
			7'd0: r = 10'd0; 7'd1: r = 10'd18; 7'd2: r = 10'd35; 7'd3: r = 10'd52;
			7'd4: r = 10'd70; 7'd5: r = 10'd87; 7'd6: r = 10'd105; 7'd7: r = 10'd122;
			7'd8: r = 10'd139; 7'd9: r = 10'd156; 7'd10: r = 10'd174; 7'd11: r = 10'd191;
			7'd12: r = 10'd208; 7'd13: r = 10'd225; 7'd14: r = 10'd242; 7'd15: r = 10'd259;
			7'd16: r = 10'd276; 7'd17: r = 10'd292; 7'd18: r = 10'd309; 7'd19: r = 10'd326;
			7'd20: r = 10'd342; 7'd21: r = 10'd358; 7'd22: r = 10'd375; 7'd23: r = 10'd391;
			7'd24: r = 10'd407; 7'd25: r = 10'd423; 7'd26: r = 10'd438; 7'd27: r = 10'd454;
			7'd28: r = 10'd470; 7'd29: r = 10'd485; 7'd30: r = 10'd500; 7'd31: r = 10'd515;
			7'd32: r = 10'd530; 7'd33: r = 10'd545; 7'd34: r = 10'd559; 7'd35: r = 10'd574;
			7'd36: r = 10'd588; 7'd37: r = 10'd602; 7'd38: r = 10'd616; 7'd39: r = 10'd629;
			7'd40: r = 10'd643; 7'd41: r = 10'd656; 7'd42: r = 10'd669; 7'd43: r = 10'd682;
			7'd44: r = 10'd695; 7'd45: r = 10'd707; 7'd46: r = 10'd719; 7'd47: r = 10'd731;
			7'd48: r = 10'd743; 7'd49: r = 10'd755; 7'd50: r = 10'd766; 7'd51: r = 10'd777;
			7'd52: r = 10'd788; 7'd53: r = 10'd799; 7'd54: r = 10'd809; 7'd55: r = 10'd819;
			7'd56: r = 10'd829; 7'd57: r = 10'd839; 7'd58: r = 10'd848; 7'd59: r = 10'd857;
			7'd60: r = 10'd866; 7'd61: r = 10'd875; 7'd62: r = 10'd883; 7'd63: r = 10'd891;
			7'd64: r = 10'd899; 7'd65: r = 10'd906; 7'd66: r = 10'd914; 7'd67: r = 10'd921;
			7'd68: r = 10'd927; 7'd69: r = 10'd934; 7'd70: r = 10'd940; 7'd71: r = 10'd946;
			7'd72: r = 10'd951; 7'd73: r = 10'd956; 7'd74: r = 10'd961; 7'd75: r = 10'd966;
			7'd76: r = 10'd970; 7'd77: r = 10'd974; 7'd78: r = 10'd978; 7'd79: r = 10'd982;
			7'd80: r = 10'd985; 7'd81: r = 10'd988; 7'd82: r = 10'd990; 7'd83: r = 10'd993;
			7'd84: r = 10'd995; 7'd85: r = 10'd996; 7'd86: r = 10'd998; 7'd87: r = 10'd999;
			7'd88: r = 10'd999; 7'd89: r = 10'd1000; 7'd90: r = 10'd1000;
			default: r = 10'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/ddou_if.sv
// Valid/ready channel interface carrying one payload.
interface ddou_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/ddou_divider.sv
// Scaler of a signed 64-bit accumulator by one million, reciprocal multiply accumulated in partial products.
module ddou_divider import ddou_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] dividend,
	output logic done,
	output logic [31:0] quotient
);
	logic [57:0] m_q;
	logic neg_q;
	logic [103:0] acc_q;
	logic [1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [63:0] mag;
	logic [28:0] opa;
	logic [29:0] opb;
	logic [58:0] pp;
	logic [103:0] addend;

	assign mag = dividend[63] ? 64'd0 - dividend : dividend;

	always_comb begin
		case (cnt_q)
			2'd0: begin opa = m_q[28:0]; opb = {1'b0, POS_RECIP[28:0]}; end
			2'd1: begin opa = m_q[28:0]; opb = POS_RECIP[58:29]; end
			2'd2: begin opa = m_q[57:29]; opb = {1'b0, POS_RECIP[28:0]}; end
			default: begin opa = m_q[57:29]; opb = POS_RECIP[58:29]; end
		endcase
	end

	assign pp = 59'(opa) * 59'(opb);

	always_comb begin
		case (cnt_q)
			2'd0: addend = {45'd0, pp};
			2'd1: addend = {16'd0, pp, 29'd0};
			2'd2: addend = {16'd0, pp, 29'd0};
			default: addend = {pp[45:0], 58'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == 2'd3);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			m_q <= mag[63:6];
			neg_q <= dividend[63];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + addend;
		end
	end

	assign done = done_q;
	assign quotient = neg_q ? 32'd0 - acc_q[103:72] : acc_q[103:72];
endmodule

FILE: hdl/ddou_datapath.sv
// Datapath: threshold, velocities, trig lookup, integration and output scaling.
module ddou_datapath import ddou_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	output sts_t sts,
	input req_t req,
	input logic [7:0] noise_threshold,
	input logic [7:0] report_period,
	output rsp_t rsp
);
	logic [9:0] lc_q, rc_q;
	logic lrev_q, rrev_q;
	logic signed [15:0] v_q;
	logic signed [17:0] w_q;
	logic [8:0] deg_q;
	logic signed [10:0] cos_q, sin_q;
	logic signed [33:0] dx_q, dy_q;
	logic [63:0] x_q, y_q;
	logic [22:0] head_q;
	logic [12:0] hmrad_q;
	logic [7:0] cnt_q;
	logic rep_q;
	logic signed [11:0] sl, sr, ssum, sdif;
	logic signed [16:0] vprod, vrnd;
	logic [10:0] wabs;
	logic [42:0] wprod;
	logic [46:0] hprod;
	logic [41:0] dprod;
	logic [6:0] idx;
	logic cneg, sneg;
	logic signed [24:0] hnext;
	logic div_start, done_x, done_y, div_done;
	logic [31:0] qx, qy;

	assign sl = lrev_q ? -$signed({2'b0, lc_q}) : $signed({2'b0, lc_q});
	assign sr = rrev_q ? -$signed({2'b0, rc_q}) : $signed({2'b0, rc_q});
	assign ssum = sr + sl;
	assign sdif = sr - sl;
	assign vprod = 17'(ssum) * 17'sd15;
	assign vrnd = vprod + $signed({16'd0, vprod[16]});
	assign wabs = sdif[11] ? 11'(-sdif) : 11'(sdif);
	assign wprod = 43'(wabs) * 43'(W_RECIP);
	assign hprod = 47'(head_q) * 47'(MRAD_RECIP);
	assign dprod = 42'(hmrad_q) * 42'(DEG_RECIP);

	always_comb begin
		cneg = 1'b0;
		sneg = 1'b0;
		idx = deg_q[6:0];
		if (deg_q > 9'd90 && deg_q <= 9'd180) begin
			idx = 7'(9'd180 - deg_q);
			cneg = 1'b1;
		end else if (deg_q > 9'd180 && deg_q <= 9'd270) begin
			idx = 7'(deg_q - 9'd180);
			cneg = 1'b1;
			sneg = 1'b1;
		end else if (deg_q > 9'd270) begin
			idx = 7'(9'd360 - deg_q);
			sneg = 1'b1;
		end
	end

	assign hnext = 25'(signed'({2'b0, head_q})) + 25'(w_q) * 25'sd20;
	assign div_start = (cmd.step == STEP_HEAD);
	assign div_done = done_x && done_y;

	ddou_divider u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(x_q),
		.done(done_x), .quotient(qx)
	);

	ddou_divider u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(y_q),
		.done(done_y), .quotient(qy)
	);

	assign sts.div_done = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			head_q <= '0;
			hmrad_q <= '0;
			cnt_q <= '0;
		end else begin
			case (cmd.step)
				STEP_ACC: begin
					x_q <= x_q + 64'(dx_q);
					y_q <= y_q + 64'(dy_q);
					if (hnext > 25'sd6283000) head_q <= 23'(hnext - 25'sd6283000);
					else if (hnext < 0) head_q <= 23'(hnext + 25'sd6283000);
					else head_q <= 23'(hnext);
					cnt_q <= (cnt_q > report_period) ? 8'd1 : cnt_q + 8'd1;
				end
				STEP_HEAD: hmrad_q <= hprod[45:33];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lc_q <= (req.left_count <= 10'(noise_threshold)) ? 10'd0 : req.left_count;
			rc_q <= (req.right_count <= 10'(noise_threshold)) ? 10'd0 : req.right_count;
			lrev_q <= req.left_reverse;
			rrev_q <= req.right_reverse;
		end
		case (cmd.step)
			STEP_VEL: begin
				v_q <= 16'(vrnd >>> 1);
				w_q <= sdif[11] ? -$signed({1'b0, wprod[42:26]}) : $signed({1'b0, wprod[42:26]});
				deg_q <= dprod[41:33];
			end
			STEP_TRIG: begin
				sin_q <= sneg ? -$signed({1'b0, sine_at(idx)}) : $signed({1'b0, sine_at(idx)});
				cos_q <= cneg ? -$signed({1'b0, sine_at(7'(7'd90 - idx))})
					: $signed({1'b0, sine_at(7'(7'd90 - idx))});
			end
			STEP_MUL: begin
				dx_q <= 34'(v_q) * 34'(cos_q) * 34'sd20;
				dy_q <= 34'(v_q) * 34'(sin_q) * 34'sd20;
			end
			STEP_ACC: rep_q <= cnt_q > report_period;
			STEP_SCALE: begin
				if (div_done) begin
					rsp.x_position <= qx;
					rsp.y_position <= qy;
					rsp.heading_mrad <= hmrad_q;
					rsp.report_valid <= rep_q;
					rsp.left_count_out <= lc_q;
					rsp.right_count_out <= rc_q;
				end
			end
			default: ;
		endcase
	end
endmodule

FILE: hdl/ddou_ctrl.sv
// Controller sequencing one request through the datapath.
module ddou_ctrl import ddou_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	output cmd_t cmd,
	input sts_t sts
);
	localparam logic [2:0] S_IDLE = STEP_IDLE;
	localparam logic [2:0] S_VEL = STEP_VEL;
	localparam logic [2:0] S_TRIG = STEP_TRIG;
	localparam logic [2:0] S_MUL = STEP_MUL;
	localparam logic [2:0] S_ACC = STEP_ACC;
	localparam logic [2:0] S_HEAD = STEP_HEAD;
	localparam logic [2:0] S_SCALE = STEP_SCALE;
	localparam logic [2:0] S_OUT = STEP_OUT;

	logic [2:0] state_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign cmd.load = in_valid && in_ready;
	assign cmd.step = state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_VEL;
				S_VEL: state_q <= S_TRIG;
				S_TRIG: state_q <= S_MUL;
				S_MUL: state_q <= S_ACC;
				S_ACC: state_q <= S_HEAD;
				S_HEAD: state_q <= S_SCALE;
				S_SCALE: if (sts.div_done) state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: hdl/diff_drive_odometry_update_top.sv
// Top level of the differential-drive odometry update block.
// Usage:
//   in  channel: one request per sample with left/right counts and direction bits.
//   out channel: one result per request with x, y, heading, report flag and counts.
//   APB port: register 0 noise_threshold (addr 0), register 1 report_period (addr 4).
// Sequence: once the request is accepted, five sequenced steps run (velocities, trig
//   lookup, multiply, integrate, heading scale); the reciprocal multiply scaling x and y
//   by one million starts with the heading scale, and one capture makes the result valid.
// Flow: one request at a time; the next request is taken only after the result is taken.
// Reset: clears position, heading, sample counter and restores register defaults.
// Stall: while the receiver holds ready low the result stays on the outputs
//   and no new request is accepted.
module diff_drive_odometry_update_top import ddou_pkg::*; (
	input logic clk,
	input logic arst_n,
	ddou_if.sink in_ch,
	ddou_if.source out_ch,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [7:0] noise_q, period_q;
	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_q <= NOISE_RESET;
			period_q <= PERIOD_RESET;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
			if (paddr[2] == REG_NOISE) noise_q <= pwdata[7:0];
			else period_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr[2] == REG_PERIOD) ? {24'd0, period_q} : {24'd0, noise_q};

	ddou_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .cmd(cmd), .sts(sts)
	);

	ddou_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .req(in_ch.payload),
		.noise_threshold(noise_q), .report_period(period_q), .rsp(out_ch.payload)
	);

`ifndef ASSERT_OFF
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid)) else $error("accept during output");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
	a_heading: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.payload.heading_mrad <= 13'd6283) else $error("heading range");
`endif
endmodule
